### rtl/bthd_pkg.sv
package bthd_pkg;

    localparam int CNT_W   = 16;
    localparam int LED_W   = 7;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [LED_W-1:0] LED_MAX      = 7'd100;
    localparam logic [LED_W-1:0] LED_MAX_BACK = 7'd99;
    localparam logic [LED_W-1:0] LED_MIN      = 7'd1;
    localparam logic [LED_W-1:0] LED_MIN_BACK = 7'd2;

    localparam logic [CNT_W-1:0] LOCKOUT_RST = 16'd5;
    localparam logic [CNT_W-1:0] WINDOW_RST  = 16'd200;
    localparam logic [CNT_W-1:0] RAMP_RST    = 16'd20;

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_LOCKOUT = 2'd0,
        REG_WINDOW  = 2'd1,
        REG_RAMP    = 2'd2,
        REG_NONE    = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_DOWN  = 2'd1,
        EV_UP    = 2'd2,
        EV_CLICK = 2'd3
    } ev_t;

    typedef struct packed {
        logic [CNT_W-1:0] lockout_ticks;
        logic [CNT_W-1:0] click_window_ticks;
        logic [CNT_W-1:0] ramp_period_ticks;
    } cfg_t;

    // a zero period behaves as one tick
    function automatic logic [CNT_W-1:0] at_least_one(input logic [CNT_W-1:0] v);
        at_least_one = (v == '0) ? {{(CNT_W-1){1'b0}}, 1'b1} : v;
    endfunction

endpackage

### rtl/button_tap_hold_dimmer.sv
// a result passes the input register, then the result register, before it shows on m_valid
// throughput: one tick per cycle unless m_ready stalls, set by the state update in bthd_core
// the input register refills in the cycle the result register drains
// reset: synchronous active-low aresetn clears both pipeline registers and the
// tap/hold state, and loads the registers with lockout 5, click window 200, ramp 20
module button_tap_hold_dimmer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_button_level,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bthd_pkg::LED_W-1:0]    m_led_level,
    output logic [1:0]                    m_event_code,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bthd_pkg::ADDR_W-1:0]   paddr,
    input  logic [bthd_pkg::DATA_W-1:0]   pwdata,
    output logic [bthd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import bthd_pkg::*;

    cfg_t             cfg;
    logic             in_valid_reg;
    logic             in_level_reg;
    logic             out_valid_reg;
    logic [LED_W-1:0] out_led_reg;
    ev_t              out_event_reg;
    logic             advance;
    logic [LED_W-1:0] core_led;
    ev_t              core_event;

    bthd_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bthd_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .level      (in_level_reg),
        .cfg        (cfg),
        .led_level  (core_led),
        .event_code (core_event)
    );

    // the tick moves on when the result register is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready)
            in_level_reg <= s_button_level;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_led_reg   <= core_led;
            out_event_reg <= core_event;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_led_level  = out_led_reg;
    assign m_event_code = out_event_reg;

endmodule

### rtl/bthd_regs.sv
module bthd_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bthd_pkg::ADDR_W-1:0]   paddr,
    input  logic [bthd_pkg::DATA_W-1:0]   pwdata,
    output logic [bthd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output bthd_pkg::cfg_t                cfg
);
    import bthd_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lockout_ticks      <= LOCKOUT_RST;
            cfg_reg.click_window_ticks <= WINDOW_RST;
            cfg_reg.ramp_period_ticks  <= RAMP_RST;
        end else if (wr_en) begin
            case (idx)
                REG_LOCKOUT: cfg_reg.lockout_ticks      <= pwdata[CNT_W-1:0];
                REG_WINDOW:  cfg_reg.click_window_ticks <= pwdata[CNT_W-1:0];
                REG_RAMP:    cfg_reg.ramp_period_ticks  <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_LOCKOUT: prdata = {{(DATA_W-CNT_W){1'b0}}, cfg_reg.lockout_ticks};
            REG_WINDOW:  prdata = {{(DATA_W-CNT_W){1'b0}}, cfg_reg.click_window_ticks};
            REG_RAMP:    prdata = {{(DATA_W-CNT_W){1'b0}}, cfg_reg.ramp_period_ticks};
            default:     prdata = '0;
        endcase
    end

endmodule

### rtl/bthd_core.sv
module bthd_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step,
    input  logic                         level,
    input  bthd_pkg::cfg_t               cfg,
    output logic [bthd_pkg::LED_W-1:0]   led_level,
    output bthd_pkg::ev_t                event_code
);
    import bthd_pkg::*;

    logic             prev_level_reg, prev_level_next;
    logic             edge_armed_reg, edge_armed_next;
    logic [CNT_W-1:0] lockout_count_reg, lockout_count_next;
    logic             click_idle_reg, click_idle_next;
    logic             click_running_reg, click_running_next;
    logic [CNT_W-1:0] click_count_reg, click_count_next;
    logic             ramp_running_reg, ramp_running_next;
    logic [CNT_W-1:0] ramp_count_reg, ramp_count_next;
    logic             falling_dir_reg, falling_dir_next;
    logic [LED_W-1:0] intensity_reg, intensity_next;
    ev_t              ev;
    logic             window_started;

    always_comb begin
        prev_level_next    = prev_level_reg;
        edge_armed_next    = edge_armed_reg;
        lockout_count_next = lockout_count_reg;
        click_idle_next    = click_idle_reg;
        click_running_next = click_running_reg;
        click_count_next   = click_count_reg;
        ramp_running_next  = ramp_running_reg;
        ramp_count_next    = ramp_count_reg;
        falling_dir_next   = falling_dir_reg;
        intensity_next     = intensity_reg;
        ev                 = EV_NONE;
        window_started     = 1'b0;

        // periodic ramp, triangle between 1 and 100
        if (ramp_running_reg) begin
            if (ramp_count_reg == 16'd1) begin
                ramp_count_next = at_least_one(cfg.ramp_period_ticks);
                if (falling_dir_reg) begin
                    if (intensity_reg <= LED_MIN) begin
                        intensity_next   = LED_MIN_BACK;
                        falling_dir_next = 1'b0;
                    end else begin
                        intensity_next = intensity_reg - 7'd1;
                    end
                end else begin
                    if (intensity_reg >= LED_MAX) begin
                        intensity_next   = LED_MAX_BACK;
                        falling_dir_next = 1'b1;
                    end else begin
                        intensity_next = intensity_reg + 7'd1;
                    end
                end
            end else begin
                ramp_count_next = ramp_count_reg - 16'd1;
            end
        end

        // lockout expiry samples the button
        if (!edge_armed_reg) begin
            lockout_count_next = lockout_count_reg - 16'd1;
            if (lockout_count_reg == 16'd1) begin
                if (click_idle_reg && level) begin
                    click_idle_next    = 1'b0;
                    click_running_next = 1'b1;
                    click_count_next   = at_least_one(cfg.click_window_ticks);
                    window_started     = 1'b1;
                end else if (!level) begin
                    ev                 = click_idle_reg ? EV_UP : EV_CLICK;
                    click_idle_next    = 1'b1;
                    click_running_next = 1'b0;
                end
                edge_armed_next = 1'b1;
            end
        end

        // click window expiry
        if (click_running_next && !window_started) begin
            click_count_next = click_count_reg - 16'd1;
            if (click_count_reg == 16'd1) begin
                if (!level)
                    ev = click_idle_next ? EV_UP : EV_CLICK;
                else
                    ev = EV_DOWN;
                click_idle_next    = 1'b1;
                click_running_next = 1'b0;
            end
        end

        case (ev)
            EV_DOWN: begin
                ramp_running_next = 1'b1;
                ramp_count_next   = at_least_one(cfg.ramp_period_ticks);
            end
            EV_UP: begin
                ramp_running_next = 1'b0;
                ramp_count_next   = '0;
            end
            EV_CLICK: begin
                // flip direction only when parked at an end
                if (intensity_next == LED_MIN || intensity_next == LED_MAX)
                    falling_dir_next = !falling_dir_next;
                intensity_next = falling_dir_next ? LED_MAX : LED_MIN;
            end
            default: ;
        endcase

        if ((level != prev_level_reg) && edge_armed_next) begin
            edge_armed_next    = 1'b0;
            lockout_count_next = at_least_one(cfg.lockout_ticks);
        end
        prev_level_next = level;
    end

    assign led_level  = intensity_next;
    assign event_code = ev;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_level_reg    <= 1'b0;
            edge_armed_reg    <= 1'b1;
            lockout_count_reg <= '0;
            click_idle_reg    <= 1'b1;
            click_running_reg <= 1'b0;
            click_count_reg   <= '0;
            ramp_running_reg  <= 1'b0;
            ramp_count_reg    <= '0;
            falling_dir_reg   <= 1'b0;
            intensity_reg     <= '0;
        end else if (step) begin
            prev_level_reg    <= prev_level_next;
            edge_armed_reg    <= edge_armed_next;
            lockout_count_reg <= lockout_count_next;
            click_idle_reg    <= click_idle_next;
            click_running_reg <= click_running_next;
            click_count_reg   <= click_count_next;
            ramp_running_reg  <= ramp_running_next;
            ramp_count_reg    <= ramp_count_next;
            falling_dir_reg   <= falling_dir_next;
            intensity_reg     <= intensity_next;
        end
    end

endmodule

### rtl/bthd_checker.sv
module bthd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [bthd_pkg::LED_W-1:0]    m_led_level,
    input logic [1:0]                    m_event_code,
    input logic                          pready
);
    import bthd_pkg::*;

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_led_level) && $stable(m_event_code))
        else $error("result changed while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_led_level <= LED_MAX)
        else $error("led level above full scale");

    // a click always parks at one end of the range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_code == EV_CLICK |-> m_led_level == LED_MIN || m_led_level == LED_MAX)
        else $error("click left led between ends");

    assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("pipeline not empty after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready dropped");

endmodule

bind button_tap_hold_dimmer bthd_checker u_bthd_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_led_level  (m_led_level),
    .m_event_code (m_event_code),
    .pready       (pready)
);

### tb/sv/tb_button_tap_hold_dimmer.sv
`timescale 1ns / 1ps

module tb_button_tap_hold_dimmer;
    import bthd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_OFF    = 80;
    localparam int DIR_N       = 25;
    localparam int N_PHASES    = 7;

    typedef enum logic [1:0] {
        GAPS_RX_HEAVY,
        GAPS_TX_HEAVY,
        GAPS_NONE
    } gaps_t;

    typedef struct packed {
        logic [LED_W-1:0] led;
        ev_t              ev;
    } dim_result_t;

    typedef struct packed {
        logic             btn;
        logic             typed_exp;
        logic [LED_W-1:0] led;
        ev_t              ev;
    } tick_row_t;

    typedef struct packed {
        logic [CNT_W-1:0] lk;
        logic [CNT_W-1:0] win;
        logic [CNT_W-1:0] rmp;
        logic [15:0]      items;
        gaps_t            gaps;
    } phase_t;

    typedef struct {
        logic             prev;
        logic             armed;
        logic [CNT_W-1:0] lock_cnt;
        logic             idle;
        logic             running;
        logic [CNT_W-1:0] win_cnt;
        logic             ramping;
        logic [CNT_W-1:0] ramp_cnt;
        logic             falling;
        logic [LED_W-1:0] level;
    } dimmer_state_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic                s_button_level;
    logic                m_valid;
    logic                m_ready;
    logic [LED_W-1:0]    m_led_level;
    logic [1:0]          m_event_code;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    button_tap_hold_dimmer DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_button_level (s_button_level),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_led_level    (m_led_level),
        .m_event_code   (m_event_code),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // directed press/release sequence, run with lockout 0, window 2, ramp 0
    tick_row_t dir_rows [DIR_N] = '{
        '{1'b0, 1'b1, 7'd0, EV_NONE},
        '{1'b1, 1'b1, 7'd0, EV_NONE},
        '{1'b1, 1'b1, 7'd0, EV_NONE},
        '{1'b0, 1'b1, 7'd0, EV_NONE},
        '{1'b0, 1'b1, 7'd1, EV_CLICK},
        '{1'b1, 1'b0, 7'd0, EV_NONE},
        '{1'b1, 1'b0, 7'd0, EV_NONE},
        '{1'b1, 1'b0, 7'd0, EV_NONE},
        '{1'b1, 1'b0, 7'd0, EV_NONE},
        '{1'b1, 1'b0, 7'd0, EV_NONE},
        '{1'b1, 1'b0, 7'd0, EV_NONE},
        '{1'b1, 1'b0, 7'd0, EV_NONE},
        '{1'b1, 1'b0, 7'd0, EV_NONE},
        '{1'b1, 1'b0, 7'd0, EV_NONE},
        '{1'b0, 1'b0, 7'd0, EV_NONE},
        '{1'b0, 1'b0, 7'd0, EV_NONE},
        '{1'b1, 1'b0, 7'd0, EV_NONE},
        '{1'b0, 1'b0, 7'd0, EV_NONE},
        '{1'b0, 1'b0, 7'd0, EV_NONE},
        '{1'b1, 1'b0, 7'd0, EV_NONE},
        '{1'b1, 1'b0, 7'd0, EV_NONE},
        '{1'b0, 1'b0, 7'd0, EV_NONE},
        '{1'b1, 1'b0, 7'd0, EV_NONE},
        '{1'b0, 1'b0, 7'd0, EV_NONE},
        '{1'b0, 1'b0, 7'd0, EV_NONE}
    };

    phase_t phases [N_PHASES] = '{
        '{16'd1,     16'd6,     16'd1,     16'd250, GAPS_RX_HEAVY},
        '{16'd3,     16'd12,    16'd2,     16'd250, GAPS_RX_HEAVY},
        '{16'd0,     16'd0,     16'd0,     16'd200, GAPS_TX_HEAVY},
        '{16'd2,     16'd4,     16'd5,     16'd250, GAPS_TX_HEAVY},
        '{16'd5,     16'd200,   16'd20,    16'd250, GAPS_NONE},
        '{16'hFFFF,  16'hFFFF,  16'hFFFF,  16'd60,  GAPS_NONE},
        '{16'd1,     16'd3,     16'd1,     16'd200, GAPS_NONE}
    };

    cfg_t          cfg;
    dimmer_state_t st;
    dim_result_t   owed_results [$];

    int  errors;
    int  ticks_sent;
    int  settings_used;
    int  src_idle_pct;
    int  snk_stall_pct;
    int  ev_seen [4];
    int  cycles;
    bit  pressure_req;
    bit  pressure_done;

    function automatic logic [CNT_W-1:0] eff_ticks(input logic [CNT_W-1:0] v);
        return (v == '0) ? CNT_W'(1) : v;
    endfunction

    function automatic int clip(input int v, input int hi);
        return (v > hi) ? hi : v;
    endfunction

    // end of a press, button sampled now
    function automatic ev_t close_press(input logic b);
        ev_t ev;
        if (!b) begin
            ev = st.idle ? EV_UP : EV_CLICK;
        end else begin
            ev = EV_DOWN;
        end
        st.idle    = 1'b1;
        st.running = 1'b0;
        return ev;
    endfunction

    function automatic void dimmer_tick(input logic b, output dim_result_t res);
        ev_t  ev;
        logic win_started;
        ev          = EV_NONE;
        win_started = 1'b0;

        if (st.ramping) begin
            st.ramp_cnt = st.ramp_cnt - 1'b1;
            if (st.ramp_cnt == '0) begin
                st.ramp_cnt = eff_ticks(cfg.ramp_period_ticks);
                // triangle between 1 and 100, bouncing back one step at each end
                if (st.falling) begin
                    if (st.level <= LED_MIN) begin
                        st.level   = LED_MIN_BACK;
                        st.falling = 1'b0;
                    end else begin
                        st.level = st.level - 1'b1;
                    end
                end else begin
                    if (st.level >= LED_MAX) begin
                        st.level   = LED_MAX_BACK;
                        st.falling = 1'b1;
                    end else begin
                        st.level = st.level + 1'b1;
                    end
                end
            end
        end

        if (!st.armed) begin
            st.lock_cnt = st.lock_cnt - 1'b1;
            if (st.lock_cnt == '0) begin
                if (st.idle && b) begin
                    st.idle     = 1'b0;
                    st.running  = 1'b1;
                    st.win_cnt  = eff_ticks(cfg.click_window_ticks);
                    win_started = 1'b1;
                end else if (!b) begin
                    ev = close_press(b);
                end
                st.armed = 1'b1;
            end
        end

        if (st.running && !win_started) begin
            st.win_cnt = st.win_cnt - 1'b1;
            if (st.win_cnt == '0) begin
                ev = close_press(b);
            end
        end

        case (ev)
            EV_DOWN: begin
                st.ramping  = 1'b1;
                st.ramp_cnt = eff_ticks(cfg.ramp_period_ticks);
            end
            EV_UP: begin
                st.ramping  = 1'b0;
                st.ramp_cnt = '0;
            end
            EV_CLICK: begin
                if (st.level == LED_MIN || st.level == LED_MAX) begin
                    st.falling = ~st.falling;
                end
                st.level = st.falling ? LED_MAX : LED_MIN;
            end
            default: begin
            end
        endcase

        if (b != st.prev && st.armed) begin
            st.armed    = 1'b0;
            st.lock_cnt = eff_ticks(cfg.lockout_ticks);
        end
        st.prev = b;

        res.led = st.level;
        res.ev  = ev;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        errors++;
    endtask

    task automatic set_gaps(input gaps_t g);
        case (g)
            GAPS_RX_HEAVY: begin
                src_idle_pct  = 28;
                snk_stall_pct = 58;
            end
            GAPS_TX_HEAVY: begin
                src_idle_pct  = 58;
                snk_stall_pct = 28;
            end
            default: begin
                src_idle_pct  = 0;
                snk_stall_pct = 0;
            end
        endcase
    endtask

    // register write, then a read back of the same register
    task automatic write_reg(input reg_idx_t idx, input logic [CNT_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= DATA_W'(val);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[CNT_W-1:0] !== val) begin
            flag_mismatch("register readback", int'(prdata[CNT_W-1:0]), int'(val));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_LOCKOUT: cfg.lockout_ticks      = val;
            REG_WINDOW:  cfg.click_window_ticks = val;
            REG_RAMP:    cfg.ramp_period_ticks  = val;
            default: begin
            end
        endcase
    endtask

    task automatic write_settings(input logic [CNT_W-1:0] lk, input logic [CNT_W-1:0] win,
                                  input logic [CNT_W-1:0] rmp);
        write_reg(REG_LOCKOUT, lk);
        write_reg(REG_WINDOW, win);
        write_reg(REG_RAMP, rmp);
        settings_used++;
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge aclk);
    endtask

    task automatic send_tick(input logic lvl, input logic typed_exp,
                             input logic [LED_W-1:0] t_led, input ev_t t_ev);
        dim_result_t res;
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_button_level <= lvl;
        do @(posedge aclk); while (s_ready !== 1'b1);
        dimmer_tick(lvl, res);
        if (typed_exp) begin
            res.led = t_led;
            res.ev  = t_ev;
        end
        owed_results.push_back(res);
        ticks_sent++;
    endtask

    task automatic send_run(input logic lvl, input int len, inout int left);
        for (int i = 0; i < len && left > 0; i++) begin
            send_tick(lvl, 1'b0, '0, EV_NONE);
            left--;
        end
    endtask

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (pressure_req && !pressure_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge aclk);
                pressure_done = 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        dim_result_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (owed_results.size() == 0) begin
                flag_mismatch("unexpected result transfer, event", int'(m_event_code), -1);
            end else begin
                want = owed_results.pop_front();
                if (m_led_level !== want.led) begin
                    flag_mismatch("led_level", int'(m_led_level), int'(want.led));
                end
                if (m_event_code !== want.ev) begin
                    flag_mismatch("event_code", int'(m_event_code), int'(want.ev));
                end
                if (!$isunknown(m_event_code)) begin
                    ev_seen[m_event_code]++;
                end
            end
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("tb_button_tap_hold_dimmer: errors");
        $finish;
    end

    initial begin
        int left;
        int kind;
        int len;
        int lk;
        int win;
        int rmp;

        errors         = 0;
        ticks_sent     = 0;
        settings_used  = 0;
        pressure_req   = 1'b0;
        pressure_done  = 1'b0;
        foreach (ev_seen[i]) ev_seen[i] = 0;
        set_gaps(GAPS_NONE);

        cfg.lockout_ticks      = LOCKOUT_RST;
        cfg.click_window_ticks = WINDOW_RST;
        cfg.ramp_period_ticks  = RAMP_RST;
        st.prev     = 1'b0;
        st.armed    = 1'b1;
        st.lock_cnt = '0;
        st.idle     = 1'b1;
        st.running  = 1'b0;
        st.win_cnt  = '0;
        st.ramping  = 1'b0;
        st.ramp_cnt = '0;
        st.falling  = 1'b0;
        st.level    = '0;

        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_button_level <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // zero registers behave as one tick
        write_settings(16'd0, 16'd2, 16'd0);
        set_gaps(GAPS_RX_HEAVY);
        for (int i = 0; i < DIR_N; i++) begin
            send_tick(dir_rows[i].btn, dir_rows[i].typed_exp, dir_rows[i].led, dir_rows[i].ev);
        end
        drain();

        for (int p = 0; p < N_PHASES; p++) begin
            write_settings(phases[p].lk, phases[p].win, phases[p].rmp);
            set_gaps(phases[p].gaps);
            if (p == N_PHASES - 1) begin
                pressure_req = 1'b1;
            end
            lk   = int'(eff_ticks(phases[p].lk));
            win  = int'(eff_ticks(phases[p].win));
            rmp  = int'(eff_ticks(phases[p].rmp));
            left = int'(phases[p].items);
            while (left > 0) begin
                kind = $urandom_range(99);
                if (kind < 25) begin
                    // bounce noise
                    len = $urandom_range(6, 1);
                    repeat (len) send_run(logic'($urandom_range(1)), $urandom_range(3, 1), left);
                end else begin
                    if (kind < 60) begin
                        len = $urandom_range(clip(lk + win, 60), 1);
                    end else begin
                        len = clip(lk + win + 1 + $urandom_range(rmp * 220), 400);
                    end
                    send_run(1'b1, len, left);
                    send_run(1'b0, $urandom_range(clip(lk + 8, 60), 1), left);
                end
            end
            drain();
        end

        repeat (8) @(posedge aclk);
        $display("covered %0d ticks over %0d register settings, with gaps on both sides and a %0d-cycle result hold-off",
                 ticks_sent, settings_used, HOLD_OFF);
        $display("events seen: %0d none, %0d down, %0d up, %0d click",
                 ev_seen[EV_NONE], ev_seen[EV_DOWN], ev_seen[EV_UP], ev_seen[EV_CLICK]);
        if (errors == 0) begin
            $display("tb_button_tap_hold_dimmer: clean");
        end else begin
            $display("tb_button_tap_hold_dimmer: errors");
        end
        $finish;
    end

endmodule
